>>> rtl/atrp_pkg.sv
`timescale 1ns / 1ps

package atrp_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ROOT_W = 24;
	localparam int RAD_W = 48;
	localparam int REM_W = 27;
	localparam int NUM_W = 25;
	localparam int XY_W = 28;
	localparam int Z_W = 25;
	localparam int ANG_W = 15;
	localparam int LANES = 2;
	localparam int LANE_ROLL = 0;
	localparam int LANE_PITCH = 1;
	localparam logic [15:0] ANG_MAX = 16'd9000;

	typedef struct packed {
		logic [RAD_W-1:0]         rad;
		logic [REM_W-1:0]         rem;
		logic [ROOT_W-1:0]        root;
		logic signed [NUM_W-1:0]  num;
	} sqrt_lane_t;

	typedef struct packed {
		logic                     valid;
		sqrt_lane_t [LANES-1:0]   lane;
	} sqrt_stage_t;

	typedef struct packed {
		logic signed [XY_W-1:0]   x;
		logic signed [XY_W-1:0]   y;
		logic signed [Z_W-1:0]    z;
		logic                     den_zero;
		logic                     num_zero;
		logic                     num_neg;
	} cordic_lane_t;

	typedef struct packed {
		logic                     valid;
		cordic_lane_t [LANES-1:0] lane;
	} cordic_stage_t;

	function automatic int atan_deg16(input int i);
		case (i)
			0: return 2949120;
			1: return 1740967;
			2: return 919879;
			3: return 466945;
			4: return 234379;
			5: return 117305;
			6: return 58666;
			7: return 29335;
			8: return 14668;
			9: return 7334;
			10: return 3667;
			11: return 1833;
			12: return 917;
			13: return 458;
			14: return 229;
			15: return 115;
			16: return 57;
			17: return 29;
			18: return 14;
			19: return 7;
			20: return 4;
			21: return 2;
			22: return 1;
			default: return 0;
		endcase
	endfunction

endpackage

>>> rtl/atrp_if.sv
`timescale 1ns / 1ps

interface atrp_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;

	modport source(output valid, output accel_x, output accel_y, output accel_z, input ready);
	modport sink(input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface atrp_out_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] roll_centideg;
	logic signed [14:0] pitch_centideg;
	logic               degenerate;

	modport source(output valid, output roll_centideg, output pitch_centideg,
		output degenerate, input ready);
	modport sink(input valid, input roll_centideg, input pitch_centideg,
		input degenerate, output ready);
endinterface

>>> rtl/atrp_sqrt_cell.sv
`timescale 1ns / 1ps

module atrp_sqrt_cell #(
	parameter int K = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  atrp_pkg::sqrt_stage_t d,
	output atrp_pkg::sqrt_stage_t q
);
	import atrp_pkg::*;

	sqrt_stage_t            nxt;
	logic                   valid_q;
	sqrt_lane_t [LANES-1:0] lane_q;

	always_comb begin
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;
		nxt = d;
		for (int l = 0; l < LANES; l++) begin
			rem_sh = {d.lane[l].rem[REM_W-3:0], d.lane[l].rad[2*K+1 -: 2]};
			trial = {1'b0, d.lane[l].root, 2'b01};
			ge = rem_sh >= trial;
			nxt.lane[l].rem = ge ? rem_sh - trial : rem_sh;
			nxt.lane[l].root = {d.lane[l].root[ROOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt.lane;
		end
	end

	assign q = {valid_q, lane_q};

endmodule

>>> rtl/atrp_cordic_cell.sv
`timescale 1ns / 1ps

module atrp_cordic_cell #(
	parameter int I = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  atrp_pkg::cordic_stage_t d,
	output atrp_pkg::cordic_stage_t q
);
	import atrp_pkg::*;

	localparam logic signed [Z_W-1:0] T = Z_W'(atan_deg16(I));

	cordic_stage_t            nxt;
	logic                     valid_q;
	cordic_lane_t [LANES-1:0] lane_q;

	always_comb begin
		logic signed [XY_W-1:0] xs;
		logic signed [XY_W-1:0] ys;
		nxt = d;
		for (int l = 0; l < LANES; l++) begin
			xs = d.lane[l].x >>> I;
			ys = d.lane[l].y >>> I;
			if (!d.lane[l].y[XY_W-1]) begin
				nxt.lane[l].x = d.lane[l].x + ys;
				nxt.lane[l].y = d.lane[l].y - xs;
				nxt.lane[l].z = d.lane[l].z + T;
			end else begin
				nxt.lane[l].x = d.lane[l].x - ys;
				nxt.lane[l].y = d.lane[l].y + xs;
				nxt.lane[l].z = d.lane[l].z - T;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q <= nxt.lane;
		end
	end

	assign q = {valid_q, lane_q};

endmodule

>>> rtl/accel_tilt_roll_pitch.sv
`timescale 1ns / 1ps
// channel  dir  payload
// samp     in   accel_x, accel_y, accel_z (signed 16 bit counts)
// ang      out  roll_centideg, pitch_centideg (signed 15 bit), degenerate
//
// one request per cycle unless ang stalls
// stages s1, s2, 24 root cells, CORDIC cell row, output; one bit or turn per cell
// arst_n clears every stage valid bit; payload registers are not reset
// a stalled result on ang holds the whole cell row, samp.ready follows it

module accel_tilt_roll_pitch #(
	parameter int CORDIC_STAGES = atrp_pkg::CORDIC_STAGES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	atrp_in_if.sink       samp,
	atrp_out_if.source    ang
);
	import atrp_pkg::*;

	logic en;
	logic v_s1, v_s2, ov_q;
	logic [30:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [NUM_W-1:0] numr_s1, nump_s1;
	sqrt_lane_t [LANES-1:0] lane_s2;

	sqrt_stage_t   sq [0:ROOT_W];
	cordic_stage_t cs [0:CORDIC_STAGES];

	logic signed [ANG_W-1:0] roll_q, pitch_q;
	logic                    degen_q;

	assign en = !ov_q || ang.ready;
	assign samp.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			v_s1 <= samp.valid;
			v_s2 <= v_s1;
			ov_q <= cs[CORDIC_STAGES].valid;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [31:0] px, py, pz;
		if (en) begin
			px = samp.accel_x * samp.accel_x;
			py = samp.accel_y * samp.accel_y;
			pz = samp.accel_z * samp.accel_z;
			sqx_s1 <= px[30:0];
			sqy_s1 <= py[30:0];
			sqz_s1 <= pz[30:0];
			numr_s1 <= -(NUM_W'(samp.accel_y) <<< 8);
			nump_s1 <= -(NUM_W'(samp.accel_x) <<< 8);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s2[LANE_ROLL].rad <= {{1'b0, sqx_s1} + {1'b0, sqz_s1}, 16'd0};
			lane_s2[LANE_PITCH].rad <= {{1'b0, sqy_s1} + {1'b0, sqz_s1}, 16'd0};
			lane_s2[LANE_ROLL].num <= numr_s1;
			lane_s2[LANE_PITCH].num <= nump_s1;
			for (int l = 0; l < LANES; l++) begin
				lane_s2[l].rem <= '0;
				lane_s2[l].root <= '0;
			end
		end
	end
	assign sq[0] = {v_s2, lane_s2};

	for (genvar g = 0; g < ROOT_W; g++) begin : g_root
		atrp_sqrt_cell #(.K(ROOT_W - 1 - g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(sq[g]), .q(sq[g+1])
		);
	end

	always_comb begin
		cs[0].valid = sq[ROOT_W].valid;
		for (int l = 0; l < LANES; l++) begin
			cs[0].lane[l].x = XY_W'(sq[ROOT_W].lane[l].root);
			cs[0].lane[l].y = XY_W'(sq[ROOT_W].lane[l].num);
			cs[0].lane[l].z = '0;
			cs[0].lane[l].den_zero = sq[ROOT_W].lane[l].root == '0;
			cs[0].lane[l].num_zero = sq[ROOT_W].lane[l].num == '0;
			cs[0].lane[l].num_neg = sq[ROOT_W].lane[l].num[NUM_W-1];
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
		atrp_cordic_cell #(.I(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(cs[g]), .q(cs[g+1])
		);
	end

	function automatic logic signed [ANG_W-1:0] to_centideg(input cordic_lane_t c);
		logic [Z_W-1:0]   mag;
		logic [31:0]      prod;
		logic [15:0]      m;
		logic [ANG_W-1:0] r;
		mag = c.z[Z_W-1] ? Z_W'(-c.z) : Z_W'(c.z);
		prod = 32'(mag) * 32'd100 + 32'd32768;
		m = prod[31:16];
		if (m > ANG_MAX) begin
			m = ANG_MAX;
		end
		r = m[ANG_W-1:0];
		if (c.den_zero) begin
			if (c.num_zero) begin
				return '0;
			end
			return c.num_neg ? -ANG_MAX[ANG_W-1:0] : ANG_MAX[ANG_W-1:0];
		end
		return c.z[Z_W-1] ? -r : r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q <= to_centideg(cs[CORDIC_STAGES].lane[LANE_ROLL]);
			pitch_q <= to_centideg(cs[CORDIC_STAGES].lane[LANE_PITCH]);
			degen_q <= (cs[CORDIC_STAGES].lane[LANE_ROLL].den_zero
				&& cs[CORDIC_STAGES].lane[LANE_ROLL].num_zero)
				|| (cs[CORDIC_STAGES].lane[LANE_PITCH].den_zero
				&& cs[CORDIC_STAGES].lane[LANE_PITCH].num_zero);
		end
	end

	assign ang.valid = ov_q;
	assign ang.roll_centideg = roll_q;
	assign ang.pitch_centideg = pitch_q;
	assign ang.degenerate = degen_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && degen_q |-> roll_q == '0 && pitch_q == '0)
		else $error("degenerate result with nonzero angle");
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> roll_q <= 15'sd9000 && roll_q >= -15'sd9000)
		else $error("roll out of range");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> pitch_q <= 15'sd9000 && pitch_q >= -15'sd9000)
		else $error("pitch out of range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(cs[CORDIC_STAGES].valid) && $stable(v_s2))
		else $error("cell row moved during stall");

endmodule
